>>> src/stack_bytecode_executor_macros.svh
// ----------------------------------------------------------------------------
// stack bytecode executor assertion macros
// shared property wrappers for the executor checks
// ----------------------------------------------------------------------------
`ifndef STACK_BYTECODE_EXECUTOR_MACROS_SVH
`define STACK_BYTECODE_EXECUTOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sbe assertion failed");

// next-cycle implication, disabled during reset
`define SBE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sbe assertion failed");

`endif

>>> src/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// opcodes, status codes, sequencer states and defaults of the executor
// ----------------------------------------------------------------------------
`default_nettype none

package sbe_pkg;

  localparam int unsigned DATA_W = 32;

  localparam int unsigned STACK_DEPTH_DEF   = 256;
  localparam int unsigned REG_COUNT_DEF     = 16;
  localparam int unsigned PROGRAM_SPACE_DEF = 65536;

  typedef enum logic [7:0] {
    OP_NOP   = 8'h00,
    OP_PUSH  = 8'h01,
    OP_POP   = 8'h02,
    OP_LOAD  = 8'h03,
    OP_STORE = 8'h04,
    OP_JMP   = 8'h05,
    OP_JZ    = 8'h06,
    OP_JNZ   = 8'h07,
    OP_ADD   = 8'h08,
    OP_SUB   = 8'h09,
    OP_MUL   = 8'h0a,
    OP_DIV   = 8'h0b,
    OP_PRINT = 8'h0c,
    OP_STOP  = 8'h0d
  } op_t;

  localparam logic [2:0] STAT_RUN    = 3'd0;
  localparam logic [2:0] STAT_STOP   = 3'd1;
  localparam logic [2:0] STAT_BADOP  = 3'd2;
  localparam logic [2:0] STAT_UNDER  = 3'd3;
  localparam logic [2:0] STAT_OVER   = 3'd4;
  localparam logic [2:0] STAT_DIVZ   = 3'd5;
  localparam logic [2:0] STAT_BADREG = 3'd6;

  // instruction lengths in bytes
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_REG  = 3'd2;
  localparam logic [2:0] LEN_JMP  = 3'd3;
  localparam logic [2:0] LEN_PUSH = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } fsm_t;

endpackage

`default_nettype wire

>>> src/sbe_stack_ram.sv
// ----------------------------------------------------------------------------
// sbe_stack_ram
// operand stack storage, one write port and two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_stack_ram #(
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             wa,
  input  logic [sbe_pkg::DATA_W-1:0] wd,
  input  logic [AW-1:0]             ra0,
  input  logic [AW-1:0]             ra1,
  output logic [sbe_pkg::DATA_W-1:0] rd0,
  output logic [sbe_pkg::DATA_W-1:0] rd1
);
  import sbe_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // reads track the current stack count every cycle
  always_ff @(posedge clk) begin
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

endmodule

`default_nettype wire

>>> src/sbe_regfile.sv
// ----------------------------------------------------------------------------
// sbe_regfile
// register file memory with per-entry valid bits, unwritten entries read zero
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_regfile #(
  parameter int unsigned COUNT = 16,
  localparam int unsigned IW = (COUNT > 1) ? $clog2(COUNT) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [IW-1:0]              wa,
  input  logic [sbe_pkg::DATA_W-1:0] wd,
  input  logic                       re,
  input  logic [IW-1:0]              ra,
  output logic [sbe_pkg::DATA_W-1:0] rd
);
  import sbe_pkg::*;

  logic [DATA_W-1:0] mem [COUNT];
  logic [COUNT-1:0]  vld_r;
  logic [DATA_W-1:0] rd_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      if (re) begin
        rd_vld_r <= vld_r[ra];
      end
    end
  end

  assign rd = rd_vld_r ? rd_r : '0;

endmodule

`default_nettype wire

>>> src/sbe_div.sv
// ----------------------------------------------------------------------------
// sbe_div
// signed truncating divider, restoring, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sbe_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [sbe_pkg::DATA_W-1:0] a,
  input  logic [sbe_pkg::DATA_W-1:0] b,
  output logic                       done,
  output logic [sbe_pkg::DATA_W-1:0] q
);
  import sbe_pkg::*;

  localparam int unsigned CNTW = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CNTW-1:0]   cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] quo_r;
  logic [DATA_W-1:0] mb_r;
  logic              neg_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, mb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNTW'(DATA_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= a[DATA_W-1] ? (DATA_W'(0) - a) : a;
      mb_r  <= b[DATA_W-1] ? (DATA_W'(0) - b) : b;
      neg_r <= a[DATA_W-1] ^ b[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_r <= diff[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign q    = neg_r ? (DATA_W'(0) - quo_r) : quo_r;

endmodule

`default_nettype wire

>>> src/stack_bytecode_executor.sv
// An instruction is accepted in S_IDLE and executed in S_EXEC once the output
// register is free, and its result beat is then registered there. A new
// instruction is taken only after the last has fired its result beat, as
// in_ready is high only in S_IDLE; div waits in S_DIV for the bit-serial
// divider. Synchronous reset clears the stack count, address,
// halt flag and register file valid bits; stack memory is not cleared.
// ----------------------------------------------------------------------------
// stack_bytecode_executor
// decoded stack machine instruction executor with stack memory and registers
// ----------------------------------------------------------------------------
`default_nettype none
`include "stack_bytecode_executor_macros.svh"

module stack_bytecode_executor #(
  parameter int unsigned STACK_DEPTH   = sbe_pkg::STACK_DEPTH_DEF,
  parameter int unsigned REG_COUNT     = sbe_pkg::REG_COUNT_DEF,
  parameter int unsigned PROGRAM_SPACE = sbe_pkg::PROGRAM_SPACE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_kind,
  input  logic signed [31:0] in_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [15:0]        out_next_addr,
  output logic               out_printed,
  output logic signed [31:0] out_print_value,
  output logic [2:0]         out_status
);
  import sbe_pkg::*;

  localparam int unsigned SAW = $clog2(STACK_DEPTH);
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  // reciprocal for reducing a jump target into the program space
  localparam longint unsigned RECIP_L =
    ((64'd1 << 32) + 64'(PROGRAM_SPACE) - 64'd1) / 64'(PROGRAM_SPACE);
  localparam logic [32:0] RECIP = 33'(RECIP_L);
  localparam logic [16:0] PS17  = 17'(PROGRAM_SPACE);

  fsm_t state_r, state_nxt;

  logic [7:0]        kind_r;
  logic [DATA_W-1:0] opnd_r;
  logic [15:0]       tq_r;
  logic [CW-1:0]     n_r, n_nxt;
  logic [15:0]       ia_r, ia_nxt;
  logic              halted_r, halted_nxt;

  logic              out_valid_r;
  logic [15:0]       out_next_addr_r;
  logic              out_printed_r;
  logic [DATA_W-1:0] out_print_value_r;
  logic [2:0]        out_status_r;

  logic              accept;
  logic              out_free;
  logic              fire;
  logic [15:0]       res_next;
  logic              res_printed;
  logic [DATA_W-1:0] res_pval;
  logic [2:0]        res_status;

  logic              stk_we;
  logic [SAW-1:0]    stk_wa;
  logic [DATA_W-1:0] stk_wd;
  logic [DATA_W-1:0] tos_q, nos_q;
  logic              rf_we;
  logic [DATA_W-1:0] rf_rd;
  logic              div_start, div_done;
  logic [DATA_W-1:0] div_q;

  logic [CW-1:0]     n_m1, n_m2;
  logic              full, empty, lt2, bad_reg, take;
  logic [15:0]       inc1, inc2, inc3, inc5, tgt;
  logic [48:0]       tq_prod;
  logic [32:0]       tm_prod;
  logic [63:0]       mul_prod;

  function automatic logic [15:0] add_wrap(input logic [15:0] a, input logic [2:0] len);
    logic [16:0] sum;
    sum = {1'b0, a} + 17'(len);
    if (sum >= PS17) begin
      sum = sum - PS17;
    end
    return sum[15:0];
  endfunction

  assign n_m1 = n_r - CW'(1);
  assign n_m2 = n_r - CW'(2);

  sbe_stack_ram #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk(clk),
    .we (stk_we),
    .wa (stk_wa),
    .wd (stk_wd),
    .ra0(n_m1[SAW-1:0]),
    .ra1(n_m2[SAW-1:0]),
    .rd0(tos_q),
    .rd1(nos_q)
  );

  sbe_regfile #(
    .COUNT(REG_COUNT)
  ) u_regs (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (rf_we),
    .wa   (opnd_r[RIW-1:0]),
    .wd   (tos_q),
    .re   (accept),
    .ra   (in_operand[RIW-1:0]),
    .rd   (rf_rd)
  );

  sbe_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .a    (nos_q),
    .b    (tos_q),
    .done (div_done),
    .q    (div_q)
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // target quotient is taken at accept, remainder formed in execute
  assign tq_prod  = 49'($unsigned(in_operand[15:0])) * 49'(RECIP);
  assign tm_prod  = 33'(tq_r) * 33'(PS17);
  assign tgt      = opnd_r[15:0] - tm_prod[15:0];
  assign mul_prod = 64'(nos_q) * 64'(tos_q);

  assign full    = (n_r >= CW'(STACK_DEPTH));
  assign empty   = (n_r == '0);
  assign lt2     = (n_r < CW'(2));
  assign bad_reg = ({1'b0, opnd_r[7:0]} >= 9'(REG_COUNT));
  assign take    = ((kind_r == OP_JZ) == (tos_q == '0));
  assign inc1    = add_wrap(ia_r, LEN_ONE);
  assign inc2    = add_wrap(ia_r, LEN_REG);
  assign inc3    = add_wrap(ia_r, LEN_JMP);
  assign inc5    = add_wrap(ia_r, LEN_PUSH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    fire        = 1'b0;
    res_next    = ia_r;
    res_printed = 1'b0;
    res_pval    = '0;
    res_status  = STAT_RUN;
    stk_we      = 1'b0;
    stk_wa      = n_r[SAW-1:0];
    stk_wd      = opnd_r;
    rf_we       = 1'b0;
    n_nxt       = n_r;
    div_start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          fire      = 1'b1;
          state_nxt = S_IDLE;
          if (halted_r) begin
            res_status = STAT_STOP;
          end else begin
            case (kind_r)
              OP_NOP: begin
                res_next = inc1;
              end
              OP_PUSH: begin
                if (full) begin
                  res_status = STAT_OVER;
                end else begin
                  stk_we   = 1'b1;
                  n_nxt    = n_r + CW'(1);
                  res_next = inc5;
                end
              end
              OP_POP: begin
                if (empty) begin
                  res_status = STAT_UNDER;
                end else begin
                  n_nxt    = n_m1;
                  res_next = inc1;
                end
              end
              OP_LOAD: begin
                if (bad_reg) begin
                  res_status = STAT_BADREG;
                end else if (full) begin
                  res_status = STAT_OVER;
                end else begin
                  stk_we   = 1'b1;
                  stk_wd   = rf_rd;
                  n_nxt    = n_r + CW'(1);
                  res_next = inc2;
                end
              end
              OP_STORE: begin
                if (bad_reg) begin
                  res_status = STAT_BADREG;
                end else if (empty) begin
                  res_status = STAT_UNDER;
                end else begin
                  rf_we    = 1'b1;
                  n_nxt    = n_m1;
                  res_next = inc2;
                end
              end
              OP_JMP: begin
                res_next = tgt;
              end
              OP_JZ, OP_JNZ: begin
                if (empty) begin
                  res_status = STAT_UNDER;
                end else begin
                  n_nxt    = n_m1;
                  res_next = take ? tgt : inc3;
                end
              end
              OP_ADD, OP_SUB, OP_MUL: begin
                if (lt2) begin
                  res_status = STAT_UNDER;
                end else begin
                  stk_we   = 1'b1;
                  stk_wa   = n_m2[SAW-1:0];
                  n_nxt    = n_m1;
                  res_next = inc1;
                  case (kind_r)
                    OP_ADD:  stk_wd = nos_q + tos_q;
                    OP_SUB:  stk_wd = nos_q - tos_q;
                    default: stk_wd = mul_prod[DATA_W-1:0];
                  endcase
                end
              end
              OP_DIV: begin
                if (lt2) begin
                  res_status = STAT_UNDER;
                end else if (tos_q == '0) begin
                  res_status = STAT_DIVZ;
                end else begin
                  // hold the beat back until the quotient is ready
                  fire      = 1'b0;
                  div_start = 1'b1;
                  state_nxt = S_DIV;
                end
              end
              OP_PRINT: begin
                if (empty) begin
                  res_status = STAT_UNDER;
                end else begin
                  res_printed = 1'b1;
                  res_pval    = tos_q;
                  n_nxt       = n_m1;
                  res_next    = inc1;
                end
              end
              OP_STOP: begin
                res_status = STAT_STOP;
              end
              default: begin
                res_status = STAT_BADOP;
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_done && out_free) begin
          fire      = 1'b1;
          state_nxt = S_IDLE;
          stk_we    = 1'b1;
          stk_wa    = n_m2[SAW-1:0];
          stk_wd    = div_q;
          n_nxt     = n_m1;
          res_next  = inc1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign halted_nxt = (fire && (res_status != STAT_RUN)) ? 1'b1 : halted_r;
  assign ia_nxt     = fire ? res_next : ia_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r         <= '0;
      ia_r        <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      n_r      <= n_nxt;
      ia_r     <= ia_nxt;
      halted_r <= halted_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      opnd_r <= $unsigned(in_operand);
      tq_r   <= tq_prod[47:32];
    end
    if (fire) begin
      out_next_addr_r   <= res_next;
      out_printed_r     <= res_printed;
      out_print_value_r <= res_pval;
      out_status_r      <= res_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_addr   = out_next_addr_r;
  assign out_printed     = out_printed_r;
  assign out_print_value = $signed(out_print_value_r);
  assign out_status      = out_status_r;

  `SBE_ASSERT_NEXT(a_accept_exec, clk, rst_n, in_valid && in_ready, state_r == S_EXEC)
  `SBE_ASSERT_IMP(a_print_running, clk, rst_n, out_valid && out_printed, out_status == STAT_RUN)
  `SBE_ASSERT_NEXT(a_halt_sticks, clk, rst_n, halted_r, halted_r)
  `SBE_ASSERT_IMP(a_stack_bound, clk, rst_n, 1'b1, n_r <= CW'(STACK_DEPTH))

endmodule

`default_nettype wire

>>> bench/stack_bytecode_executor_test.sv
// ----------------------------------------------------------------------------
// stack_bytecode_executor_test
// Runs decoded instructions through the executor over valid/ready on both
// sides with random idle cycles, and checks every result beat against an
// in-bench model of the stack, register file, address and halt flag, or
// against the table where a directed row gives it. A short directed table
// comes first, then random well-formed programs, then one random halt case.
// ----------------------------------------------------------------------------
module stack_bytecode_executor_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sbe_pkg::*;

  localparam int MIXED_ITEMS = 1720;
  localparam int AFTER_HALT  = 24;
  localparam int DRAIN_WAIT  = 48;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [15:0] next_addr;
    logic        printed;
    logic [31:0] print_value;
    logic [2:0]  status;
  } outcome_t;

  typedef struct {
    logic [7:0]  kind;
    logic [31:0] operand;
    bit          known;
    outcome_t    want;
  } instr_row_t;

  localparam outcome_t OPEN_OUTCOME = '{16'd0, 1'b0, 32'd0, STAT_RUN};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         in_kind = 8'd0;
  logic signed [31:0] in_operand = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [15:0]        out_next_addr;
  logic               out_printed;
  logic signed [31:0] out_print_value;
  logic [2:0]         out_status;

  // machine state as the bench sees it
  logic [31:0] stk [STACK_DEPTH_DEF];
  logic [31:0] regs [REG_COUNT_DEF];
  int          depth;
  logic [15:0] pc;
  bit          halted;

  outcome_t    pending_outcomes [$];
  instr_row_t  dir_rows [$];
  int          failures;
  int          beats_checked;
  int          deepest;
  int          divides;
  int          fill_target;
  int          cycle_count;
  bit          no_idle;

  stack_bytecode_executor DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_operand     (in_operand),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_next_addr  (out_next_addr),
    .out_printed    (out_printed),
    .out_print_value(out_print_value),
    .out_status     (out_status)
  );

  always #5 clk = ~clk;

  function automatic outcome_t execute_instr(input logic [7:0] k, input logic [31:0] opnd);
    outcome_t    res;
    logic [15:0] nxt;
    logic [2:0]  st;
    logic [31:0] a, b, v, ma, mb, q;
    int unsigned ri;
    res = '0;
    nxt = pc;
    st = STAT_RUN;
    ri = {24'd0, opnd[7:0]};
    if (halted) begin
      res.next_addr = pc;
      res.status = STAT_STOP;
      return res;
    end
    case (k)
      OP_NOP: nxt = pc + LEN_ONE;
      OP_PUSH: begin
        if (depth >= STACK_DEPTH_DEF) begin
          st = STAT_OVER;
        end else begin
          stk[depth] = opnd;
          depth++;
          nxt = pc + LEN_PUSH;
        end
      end
      OP_POP: begin
        if (depth < 1) begin
          st = STAT_UNDER;
        end else begin
          depth--;
          nxt = pc + LEN_ONE;
        end
      end
      OP_LOAD: begin
        if (ri >= REG_COUNT_DEF) begin
          st = STAT_BADREG;
        end else if (depth >= STACK_DEPTH_DEF) begin
          st = STAT_OVER;
        end else begin
          stk[depth] = regs[ri];
          depth++;
          nxt = pc + LEN_REG;
        end
      end
      OP_STORE: begin
        if (ri >= REG_COUNT_DEF) begin
          st = STAT_BADREG;
        end else if (depth < 1) begin
          st = STAT_UNDER;
        end else begin
          regs[ri] = stk[depth - 1];
          depth--;
          nxt = pc + LEN_REG;
        end
      end
      OP_JMP: nxt = opnd[15:0];
      OP_JZ, OP_JNZ: begin
        if (depth < 1) begin
          st = STAT_UNDER;
        end else begin
          depth--;
          if ((k == OP_JZ) == (stk[depth] == 32'd0)) nxt = opnd[15:0];
          else nxt = pc + LEN_JMP;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (depth < 2) begin
          st = STAT_UNDER;
        end else begin
          b = stk[depth - 1];
          a = stk[depth - 2];
          if (k == OP_DIV && b == 32'd0) begin
            st = STAT_DIVZ;
          end else begin
            case (k)
              OP_ADD: v = a + b;
              OP_SUB: v = a - b;
              OP_MUL: v = a * b;
              default: begin
                // truncate toward zero on magnitudes, min / -1 wraps to min
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                v = (a[31] ^ b[31]) ? -q : q;
                divides++;
              end
            endcase
            stk[depth - 2] = v;
            depth--;
            nxt = pc + LEN_ONE;
          end
        end
      end
      OP_PRINT: begin
        if (depth < 1) begin
          st = STAT_UNDER;
        end else begin
          depth--;
          res.printed = 1'b1;
          res.print_value = stk[depth];
          nxt = pc + LEN_ONE;
        end
      end
      OP_STOP: st = STAT_STOP;
      default: st = STAT_BADOP;
    endcase
    if (st != STAT_RUN) begin
      halted = 1'b1;
      nxt = pc;
      res.printed = 1'b0;
      res.print_value = 32'd0;
    end
    if (depth > deepest) deepest = depth;
    pc = nxt;
    res.next_addr = nxt;
    res.status = st;
    return res;
  endfunction

  function automatic int idle_cycles();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4, 5: return 32'($urandom_range(0, 16)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  // one instruction beat; valid is only lowered when a gap is drawn
  task automatic issue(input logic [7:0] k, input logic [31:0] opnd, input bit known,
                       input outcome_t want);
    int       gap;
    outcome_t pred;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_operand <= opnd;
    do @(posedge clk); while (!in_ready);
    pred = execute_instr(k, opnd);
    pending_outcomes.push_back(known ? want : pred);
  endtask

  task automatic random_instr(output logic [7:0] k, output logic [31:0] opnd);
    int r;
    opnd = $urandom();
    r = $urandom_range(0, 99);
    if (depth < fill_target) r = 0;
    else fill_target = 0;
    if (r < 22 && depth < STACK_DEPTH_DEF) begin
      k = OP_PUSH;
      opnd = pick_word();
    end else if (r < 30 && depth < STACK_DEPTH_DEF) begin
      k = OP_LOAD;
      opnd[7:0] = 8'($urandom_range(0, REG_COUNT_DEF - 1));
    end else if (r < 38 && depth >= 1) begin
      k = OP_STORE;
      opnd[7:0] = 8'($urandom_range(0, REG_COUNT_DEF - 1));
    end else if (r < 44 && depth >= 1) begin
      k = OP_POP;
    end else if (r < 52) begin
      k = OP_NOP;
    end else if (r < 58) begin
      k = OP_JMP;
    end else if (r < 66 && depth >= 1) begin
      k = (r < 62) ? OP_JZ : OP_JNZ;
    end else if (r < 90 && depth >= 2) begin
      k = (r < 74) ? OP_ADD : (r < 82) ? OP_SUB : OP_MUL;
    end else if (r < 94 && depth >= 2 && stk[depth - 1] != 32'd0) begin
      k = OP_DIV;
    end else if (r >= 94 && depth >= 1) begin
      k = OP_PRINT;
    end else begin
      k = (depth < STACK_DEPTH_DEF) ? OP_PUSH : OP_POP;
      opnd = pick_word();
    end
  endtask

  task automatic drain_stack();
    while (depth > 0) issue(OP_POP, $urandom(), 1'b0, OPEN_OUTCOME);
  endtask

  task automatic fill_stack();
    while (depth < STACK_DEPTH_DEF) issue(OP_PUSH, pick_word(), 1'b0, OPEN_OUTCOME);
  endtask

  // the halt is sticky until reset, so only one halting case fits in a run
  task automatic end_with_fault(output string why);
    logic [7:0]  under_ops [9];
    logic [7:0]  k;
    logic [31:0] opnd;
    under_ops = '{OP_POP, OP_PRINT, OP_JZ, OP_JNZ, OP_STORE, OP_ADD, OP_SUB, OP_MUL, OP_DIV};
    opnd = $urandom();
    case ($urandom_range(0, 5))
      0: begin
        why = "stop";
        issue(OP_STOP, opnd, 1'b1, outcome_t'{pc, 1'b0, 32'd0, STAT_STOP});
      end
      1: begin
        why = "unknown opcode";
        k = 8'($urandom_range(OP_STOP + 1, 255));
        issue(k, opnd, 1'b1, outcome_t'{pc, 1'b0, 32'd0, STAT_BADOP});
      end
      2: begin
        why = "stack underflow";
        k = under_ops[$urandom_range(0, 8)];
        opnd[7:0] = 8'($urandom_range(0, REG_COUNT_DEF - 1));
        drain_stack();
        // one entry is still too few for two-operand ops; a zero top on div
        // must report underflow, not divide by zero
        if (k >= OP_ADD && k <= OP_DIV && $urandom_range(0, 1) == 1)
          issue(OP_PUSH, (k == OP_DIV) ? 32'd0 : pick_word(), 1'b0, OPEN_OUTCOME);
        issue(k, opnd, 1'b1, outcome_t'{pc, 1'b0, 32'd0, STAT_UNDER});
      end
      3: begin
        why = "stack overflow";
        k = ($urandom_range(0, 1) == 1) ? OP_PUSH : OP_LOAD;
        opnd[7:0] = 8'($urandom_range(0, REG_COUNT_DEF - 1));
        fill_stack();
        issue(k, opnd, 1'b1, outcome_t'{pc, 1'b0, 32'd0, STAT_OVER});
      end
      4: begin
        why = "divide by zero";
        if (depth == 0) issue(OP_PUSH, pick_word(), 1'b0, OPEN_OUTCOME);
        if (depth == STACK_DEPTH_DEF) issue(OP_POP, opnd, 1'b0, OPEN_OUTCOME);
        issue(OP_PUSH, 32'd0, 1'b0, OPEN_OUTCOME);
        issue(OP_DIV, opnd, 1'b1, outcome_t'{pc, 1'b0, 32'd0, STAT_DIVZ});
      end
      default: begin
        why = "bad register";
        k = ($urandom_range(0, 1) == 1) ? OP_LOAD : OP_STORE;
        opnd[7:0] = 8'($urandom_range(REG_COUNT_DEF, 255));
        // register index is checked ahead of the stack
        if ($urandom_range(0, 1) == 1) begin
          if (k == OP_STORE) drain_stack();
          else fill_stack();
        end
        issue(k, opnd, 1'b1, outcome_t'{pc, 1'b0, 32'd0, STAT_BADREG});
      end
    endcase
  endtask

  initial begin : stimulus
    logic [7:0]  k;
    logic [31:0] opnd;
    string       why;
    int          ignored;
    foreach (stk[i]) stk[i] = 32'd0;
    foreach (regs[i]) regs[i] = 32'd0;
    depth = 0;
    pc = 16'd0;
    halted = 1'b0;
    failures = 0;
    beats_checked = 0;
    deepest = 0;
    divides = 0;
    fill_target = 0;
    no_idle = 1'b0;
    ignored = 0;
    dir_rows = '{
      '{OP_NOP,   32'h0000_0000, 1'b1, '{16'd1,  1'b0, 32'h0, STAT_RUN}},
      '{OP_PUSH,  32'h8000_0000, 1'b1, '{16'd6,  1'b0, 32'h0, STAT_RUN}},
      '{OP_PUSH,  32'hffff_ffff, 1'b1, '{16'd11, 1'b0, 32'h0, STAT_RUN}},
      '{OP_DIV,   32'h0000_0000, 1'b0, OPEN_OUTCOME},
      '{OP_PRINT, 32'h0000_0000, 1'b1, '{16'd13, 1'b1, 32'h8000_0000, STAT_RUN}},
      '{OP_PUSH,  32'h7fff_ffff, 1'b0, OPEN_OUTCOME},
      '{OP_PUSH,  32'h0000_0001, 1'b0, OPEN_OUTCOME},
      '{OP_ADD,   32'h0000_0000, 1'b0, OPEN_OUTCOME},
      '{OP_STORE, 32'hffff_ff0f, 1'b0, OPEN_OUTCOME},
      '{OP_LOAD,  32'h7fff_ff0f, 1'b0, OPEN_OUTCOME},
      '{OP_PUSH,  32'hffff_fff9, 1'b0, OPEN_OUTCOME},
      '{OP_PUSH,  32'h0000_0002, 1'b0, OPEN_OUTCOME},
      '{OP_DIV,   32'h0000_0000, 1'b0, OPEN_OUTCOME},
      '{OP_MUL,   32'h0000_0000, 1'b0, OPEN_OUTCOME},
      '{OP_PUSH,  32'h0000_0005, 1'b0, OPEN_OUTCOME},
      '{OP_SUB,   32'h0000_0000, 1'b0, OPEN_OUTCOME},
      '{OP_STORE, 32'h0000_0000, 1'b0, OPEN_OUTCOME},
      '{OP_PUSH,  32'h0000_0000, 1'b0, OPEN_OUTCOME},
      '{OP_JZ,    32'h0000_ffff, 1'b1, '{16'hffff, 1'b0, 32'h0, STAT_RUN}},
      '{OP_NOP,   32'hffff_ffff, 1'b1, '{16'h0000, 1'b0, 32'h0, STAT_RUN}},
      '{OP_PUSH,  32'h0000_0003, 1'b0, OPEN_OUTCOME},
      '{OP_JNZ,   32'h1234_0100, 1'b0, OPEN_OUTCOME},
      '{OP_PUSH,  32'h0000_0000, 1'b0, OPEN_OUTCOME},
      '{OP_JNZ,   32'h0000_0200, 1'b0, OPEN_OUTCOME},
      '{OP_JMP,   32'habcd_0040, 1'b0, OPEN_OUTCOME},
      '{OP_LOAD,  32'h0000_0000, 1'b0, OPEN_OUTCOME},
      '{OP_PRINT, 32'h0000_0000, 1'b0, OPEN_OUTCOME}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      issue(dir_rows[i].kind, dir_rows[i].operand, dir_rows[i].known, dir_rows[i].want);

    for (int n = 0; n < MIXED_ITEMS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      // now and then build a deep stack to work near the top
      if (fill_target == 0 && $urandom_range(0, 199) == 0)
        fill_target = $urandom_range(32, STACK_DEPTH_DEF);
      random_instr(k, opnd);
      issue(k, opnd, 1'b0, OPEN_OUTCOME);
    end

    no_idle = 1'b0;
    end_with_fault(why);
    repeat (AFTER_HALT) begin
      issue(8'($urandom_range(0, 255)), $urandom(), 1'b0, OPEN_OUTCOME);
      ignored++;
    end
    in_valid <= 1'b0;

    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d directed and %0d mixed instructions, %0d divides, stack depth up to %0d",
             dir_rows.size(), MIXED_ITEMS, divides, deepest);
    $display("halted by %s, %0d beats ignored afterwards, %0d result beats checked",
             why, ignored, beats_checked);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin : result_sink
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = idle_cycles();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result beat with no instruction outstanding");
        failures++;
      end else begin
        want = pending_outcomes.pop_front();
        beats_checked++;
        if (out_next_addr !== want.next_addr) begin
          $error("next_addr: expected %h, got %h", want.next_addr, out_next_addr);
          failures++;
        end
        if (out_printed !== want.printed) begin
          $error("printed: expected %b, got %b", want.printed, out_printed);
          failures++;
        end
        if (out_print_value !== want.print_value) begin
          $error("print_value: expected %h, got %h", want.print_value, out_print_value);
          failures++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule

>>> sim.f
+incdir+src
src/sbe_pkg.sv
src/sbe_stack_ram.sv
src/sbe_regfile.sv
src/sbe_div.sv
src/stack_bytecode_executor.sv
bench/stack_bytecode_executor_test.sv
